@@ rtl/assert_macros.svh @@
// Assertion macros used by the top RTL file of the box blur block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("assertion failed");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, ck, rs, cond)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

@@ rtl/bbea_pkg.sv @@
// Shared types and constants of the 3x3 box blur block.
// No dependencies; used by every module of the block.
package bbea_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int SUM_W  = 12;   // nine 8-bit values

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  // pixel count of a clipped neighborhood
  localparam logic [1:0] N_FOUR = 2'd0;
  localparam logic [1:0] N_SIX  = 2'd1;
  localparam logic [1:0] N_NINE = 2'd2;

  // results one pixel owes: bit 0 the main one, bit 1 the right-edge flush,
  // bit 2 the bottom-row one, bit 3 the bottom-right corner
  typedef struct packed {
    logic [3:0] mask;
    logic       rfull;  // top window row is inside the image
    logic       cfull;  // same for the left window column
  } job_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;  // blue, green, red from the top
    logic [1:0]            ncode;
    logic                  last_run;
    logic                  last_img;
  } sum_word_t;

endpackage

@@ rtl/box_blur_3x3_edge_average.sv @@
// 3x3 box blur of an RGB raster stream, averaging the in-image neighbors.
// Each result passes the input stage, the 3x3 window, the sum register and the output register.
// Throughput, while the output is not stalled: one pixel a cycle; a pixel owing k words
// holds the input until its last word issues; k is two at the right edge or on the
// bottom row, four at the bottom-right corner, as the window issues one word a cycle.
// Reset: size 640x480, position (0,0), pipeline empty; line stores untouched.
module box_blur_3x3_edge_average #(
  parameter int MAX_WIDTH  = bbea_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbea_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bbea_pkg::PIX_W-1:0]      s_axis_tdata,   // in_red, in_green, in_blue
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bbea_pkg::PIX_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
  output logic                            m_axis_tlast,   // last_of_run
  output logic                            m_axis_tuser,   // last_of_image
  input  logic                            cfg_we,
  input  logic [bbea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbea_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbea_pkg::*;

`include "assert_macros.svh"

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic [COL_W-1:0]        col;
  logic [COL_W-1:0]        col_last;
  logic [ROW_W-1:0]        row;
  logic [ROW_W-1:0]        row_last;
  logic                    in_accept;
  logic                    a_valid;
  logic [PIX_W-1:0]        a_pix;
  logic [COL_W-1:0]        a_col;
  job_t                    a_job;
  job_t                    job_in;
  logic                    take;
  logic                    load;
  logic                    en_c;
  logic                    en_d;
  logic                    c_valid;
  sum_word_t               c_word;
  logic [PIX_W-1:0]        older_rd;
  logic [PIX_W-1:0]        newer_rd;
  logic                    lc;
  logic                    lr;
  logic                    has;

  // effective size, clamped to 2..MAX
  always_comb begin
    if (image_width < 11'd2) begin
      col_last = COL_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(image_width - 11'd1);
    end
    if (image_height < 13'd2) begin
      row_last = ROW_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(image_height - 13'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_HEIGHT_W-1:0];
      endcase
    end
  end

  assign en_d          = !m_axis_tvalid || m_axis_tready;
  assign en_c          = !c_valid || en_d;
  assign load          = a_valid && take;
  assign s_axis_tready = !a_valid || take;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign lc  = (col == col_last);
  assign lr  = (row == row_last);
  assign has = (row != '0) && (col != '0);

  always_comb begin
    job_in.mask  = {has && lc && lr, has && lr, has && lc, has};
    job_in.rfull = (row >= ROW_W'(2));
    job_in.cfull = (col >= COL_W'(2));
  end

  // raster position; any size write restarts the image
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      if (lc) begin
        col <= '0;
        row <= lr ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_pix <= s_axis_tdata;
      a_col <= col;
      a_job <= job_in;
    end
  end

  bbea_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rd_en    (in_accept),
    .rd_addr  (col),
    .wr_en    (load),
    .wr_addr  (a_col),
    .wr_pix   (a_pix),
    .older_rd (older_rd),
    .newer_rd (newer_rd)
  );

  bbea_window u_window (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .pix_in   (a_pix),
    .older_rd (older_rd),
    .newer_rd (newer_rd),
    .job_in   (a_job),
    .en_c     (en_c),
    .take     (take),
    .c_valid  (c_valid),
    .c_word   (c_word)
  );

  bbea_mean u_mean (
    .clk          (clk),
    .rst          (rst),
    .en_d         (en_d),
    .c_valid      (c_valid),
    .c_word       (c_word),
    .out_valid    (m_axis_tvalid),
    .out_pix      (m_axis_tdata),
    .out_last_run (m_axis_tlast),
    .out_last_img (m_axis_tuser)
  );

  // the image corner is always the final word of its pixel's burst
  `ASSERT_HOLDS(a_img_end_is_run_end, clk, rst, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast)
  // a pixel in the input stage is never dropped while the window is busy
  `ASSERT_NEXT(a_held_pixel_kept, clk, rst, a_valid && !take, a_valid)
  // the column wraps after the last pixel of a row
  `ASSERT_NEXT(a_col_wrap, clk, rst, in_accept && !cfg_we && lc, col == '0)

endmodule

@@ rtl/bbea_line_buf.sv @@
// Two line stores holding the two rows above the incoming pixel.
// Depends on bbea_pkg. Registered read at accept, write when the item moves on.
module bbea_line_buf #(
  parameter int DEPTH = bbea_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [bbea_pkg::PIX_W-1:0]  wr_pix,
  output logic [bbea_pkg::PIX_W-1:0]  older_rd,
  output logic [bbea_pkg::PIX_W-1:0]  newer_rd
);
  import bbea_pkg::*;

  logic [PIX_W-1:0] older_line [DEPTH];
  logic [PIX_W-1:0] newer_line [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_rd <= older_line[rd_addr];
      newer_rd <= newer_line[rd_addr];
    end
  end

  // the row moves down one store; newer_rd still holds this column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_line[wr_addr] <= newer_rd;
      newer_line[wr_addr] <= wr_pix;
    end
  end

endmodule

@@ rtl/bbea_window.sv @@
// 3x3 window, result sequencer and clipped neighborhood sums.
// Depends on bbea_pkg. Issues one sum word a cycle, when en_c allows, into a registered stage.
module bbea_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [bbea_pkg::PIX_W-1:0] pix_in,
  input  logic [bbea_pkg::PIX_W-1:0] older_rd,
  input  logic [bbea_pkg::PIX_W-1:0] newer_rd,
  input  bbea_pkg::job_t             job_in,
  input  logic                       en_c,
  output logic                       take,
  output logic                       c_valid,
  output bbea_pkg::sum_word_t        c_word
);
  import bbea_pkg::*;

  logic [2:0][2:0][PIX_W-1:0] win;  // [row][col], row 0 oldest, col 2 newest
  job_t                       job;
  logic [3:0]                 sel;
  logic                       rf;
  logic                       cf;
  logic [2:0][2:0][SUM_W-3:0] colsum;
  logic [2:0][SUM_W-1:0]      tot;

  always_comb begin
    if (job.mask[0]) begin
      sel = 4'b0001; rf = job.rfull; cf = job.cfull;
    end else if (job.mask[1]) begin
      sel = 4'b0010; rf = job.rfull; cf = 1'b0;
    end else if (job.mask[2]) begin
      sel = 4'b0100; rf = 1'b0;      cf = job.cfull;
    end else begin
      sel = 4'b1000; rf = 1'b0;      cf = 1'b0;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        colsum[ch][c] = (rf ? {2'b00, win[0][c][ch*CHAN_W +: CHAN_W]} : '0)
                      + {2'b00, win[1][c][ch*CHAN_W +: CHAN_W]}
                      + {2'b00, win[2][c][ch*CHAN_W +: CHAN_W]};
      end
      tot[ch] = (cf ? {2'b00, colsum[ch][0]} : '0)
              + {2'b00, colsum[ch][1]}
              + {2'b00, colsum[ch][2]};
    end
  end

  // free for the next pixel once the last owed result goes out
  assign take = (job.mask == 4'b0000) || ($onehot(job.mask) && en_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      job.mask <= 4'b0000;
    end else if (load) begin
      job <= job_in;
    end else if (en_c) begin
      job.mask <= job.mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= older_rd;
      win[1][2] <= newer_rd;
      win[2][2] <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= (job.mask != 4'b0000);
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_word.sum      <= tot;
      c_word.ncode    <= rf ? (cf ? N_NINE : N_SIX) : (cf ? N_SIX : N_FOUR);
      c_word.last_run <= ((job.mask & ~sel) == 4'b0000);
      c_word.last_img <= sel[3];
    end
  end

endmodule

@@ rtl/bbea_mean.sv @@
// Rounded mean of a neighborhood sum and the output register.
// Depends on bbea_pkg. Divides by 6 and 9 through reciprocal multiplies.
module bbea_mean (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en_d,
  input  logic                       c_valid,
  input  bbea_pkg::sum_word_t        c_word,
  output logic                       out_valid,
  output logic [bbea_pkg::PIX_W-1:0] out_pix,
  output logic                       out_last_run,
  output logic                       out_last_img
);
  import bbea_pkg::*;

  // floor(x * R / 2^16) == floor(x / d) over the reachable range of x
  localparam logic [12:0] RECIP_TWELVE   = 13'd5462;
  localparam logic [12:0] RECIP_EIGHTEEN = 13'd3641;

  logic [2:0][CHAN_W-1:0] q;

  always_comb begin
    logic [12:0] x;
    logic [12:0] recip;
    logic [25:0] prod;
    logic [SUM_W-1:0] s4;
    for (int ch = 0; ch < 3; ch++) begin
      // x = 2*sum + n
      x     = {c_word.sum[ch], 1'b0} + ((c_word.ncode == N_NINE) ? 13'd9 : 13'd6);
      recip = (c_word.ncode == N_NINE) ? RECIP_EIGHTEEN : RECIP_TWELVE;
      prod  = x * recip;
      s4    = c_word.sum[ch] + 12'd2;
      case (c_word.ncode) inside
        N_NINE, N_SIX: q[ch] = prod[23:16];
        default:       q[ch] = s4[9:2];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_d) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      out_pix      <= q;
      out_last_run <= c_word.last_run;
      out_last_img <= c_word.last_img;
    end
  end

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for box_blur_3x3_edge_average: directed table, then random image streams.
// Depends on bbea_pkg and the block; a built-in predictor tracks line stores, window and position.
module testbench;
  import bbea_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG = 4000;
  localparam int DIR_N = 27;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_end;
    logic       img_end;
  } blur_word_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [PIX_W-1:0]       pix;
    logic                   typed;  // want holds the color of every result of this pixel
    logic [PIX_W-1:0]       want;
  } stim_row_t;

  // pixels pack red in the low byte, then green, then blue
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    '{1'b1, REG_IMAGE_WIDTH,  13'd2, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, REG_IMAGE_HEIGHT, 13'd2, 24'h000000, 1'b0, 24'h000000},
    // saturated 2x2 image: all four results come on the last pixel
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b1, 24'h000000},
    // sizes below the minimum act as 2; small sums probe the half-up rounding
    '{1'b1, REG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, REG_IMAGE_HEIGHT, 13'd1, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000001, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h010001, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFF0100, 1'b0, 24'h000000},
    // 3x3 image: corners, edges and the one interior pixel
    '{1'b1, REG_IMAGE_WIDTH,  13'd3, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, REG_IMAGE_HEIGHT, 13'd3, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h0000FF, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFFFFFF, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h00FF00, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h808080, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h7F7F7F, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFF0000, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h000001, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'h010203, 1'b0, 24'h000000},
    '{1'b0, REG_IMAGE_WIDTH,  13'd0, 24'hFEFDFC, 1'b0, 24'h000000}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;   // in_red, in_green, in_blue
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [PIX_W-1:0]       m_axis_tdata;        // out_red, out_green, out_blue
  logic                   m_axis_tlast;        // last_of_run
  logic                   m_axis_tuser;        // last_of_image
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  box_blur_3x3_edge_average uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0] line_old [MAXW];
  logic [PIX_W-1:0] line_new [MAXW];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      col_pos, row_pos, size_w, size_h;

  blur_word_t  blur_q [$];
  int unsigned mismatches = 0;
  int unsigned word_count = 0;
  int unsigned stall_cycles = 0;
  idle_mode_t  idle_mode = IDLE_NONE;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // clipped-neighborhood mean over window rows rlo..2, columns clo..2
  function automatic blur_word_t window_mean(int rlo, int clo, logic img_end);
    int unsigned s [3];
    int unsigned n;
    blur_word_t  w;
    s = '{0, 0, 0};
    n = 0;
    for (int r = rlo; r < 3; r++) begin
      for (int c = clo; c < 3; c++) begin
        for (int ch = 0; ch < 3; ch++) s[ch] += win[r][c][8*ch +: 8];
        n++;
      end
    end
    w.red     = 8'((2 * s[0] + n) / (2 * n));
    w.green   = 8'((2 * s[1] + n) / (2 * n));
    w.blue    = 8'((2 * s[2] + n) / (2 * n));
    w.run_end = 1'b0;
    w.img_end = img_end;
    return w;
  endfunction

  task automatic blur_predict(input logic [PIX_W-1:0] px, input logic typed,
                              input logic [PIX_W-1:0] want);
    int unsigned w, h, j, i;
    int          rlo, clo, nres;
    blur_word_t  res [4];
    w = clamp_dim(size_w, MAXW);
    h = clamp_dim(size_h, MAXH);
    nres = 0;
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    j = col_pos;
    i = row_pos;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_old[j];
    win[1][2] = line_new[j];
    win[2][2] = px;
    line_old[j] = line_new[j];
    line_new[j] = px;
    if (i >= 1 && j >= 1) begin
      rlo = (i >= 2) ? 0 : 1;
      clo = (j >= 2) ? 0 : 1;
      res[nres++] = window_mean(rlo, clo, 1'b0);
      if (j == w - 1) res[nres++] = window_mean(rlo, 1, 1'b0);
      // bottom row is flushed alongside the row above it
      if (i == h - 1) begin
        res[nres++] = window_mean(1, clo, 1'b0);
        if (j == w - 1) res[nres++] = window_mean(1, 1, 1'b1);
      end
    end
    for (int k = 0; k < nres; k++) begin
      res[k].run_end = (k == nres - 1);
      if (typed) {res[k].blue, res[k].green, res[k].red} = want;
      blur_q.push_back(res[k]);
    end
    if (j + 1 >= w) begin
      col_pos = 0;
      row_pos = (i + 1 >= h) ? 0 : i + 1;
    end else begin
      col_pos = j + 1;
    end
  endtask

  function automatic logic send_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 80;
      IDLE_BOTH: return $urandom_range(99) < 21;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 80;
      IDLE_BOTH: return $urandom_range(99) < 21;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // all tasks below start and end at a falling edge
  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic typed,
                            input logic [PIX_W-1:0] want);
    while (send_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    blur_predict(px, typed, want);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) size_w = val[CFG_WIDTH_W-1:0];
    else                        size_h = val[CFG_HEIGHT_W-1:0];
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and let every pending word drain, plus a margin for
  // pixels that produce nothing but may still be in flight
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (blur_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) m_axis_tready <= !recv_stall();

  always @(posedge clk) begin
    blur_word_t got, exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.red     = m_axis_tdata[7:0];
      got.green   = m_axis_tdata[15:8];
      got.blue    = m_axis_tdata[23:16];
      got.run_end = m_axis_tlast;
      got.img_end = m_axis_tuser;
      if (blur_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: unexpected r=%h g=%h b=%h last=%b img=%b", word_count,
                   got.red, got.green, got.blue, got.run_end, got.img_end);
      end else begin
        exp_w = blur_q.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: want rgb=%h%h%h last=%b img=%b, got rgb=%h%h%h last=%b img=%b",
                     word_count, exp_w.red, exp_w.green, exp_w.blue, exp_w.run_end,
                     exp_w.img_end, got.red, got.green, got.blue, got.run_end, got.img_end);
        end
      end
      word_count++;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG) begin
      $display("box_blur_3x3_edge_average: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned n_items;
    size_w  = RESET_WIDTH;
    size_h  = RESET_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    foreach (line_old[k]) begin
      line_old[k] = '0;
      line_new[k] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < DIR_N; k++) begin
      if (DIR_TAB[k].is_cfg) begin
        settle_idle();
        cfg_write(DIR_TAB[k].idx, DIR_TAB[k].val);
      end else begin
        push_pixel(DIR_TAB[k].pix, DIR_TAB[k].typed, DIR_TAB[k].want);
      end
    end

    for (int p = 0; p < 10; p++) begin
      settle_idle();
      idle_mode = idle_mode_t'(p % 4);
      if (p == 4) begin
        // upper data bits are dropped, leaving a width of 3
        cfg_write(REG_IMAGE_WIDTH, 13'h1803);
        cfg_write(REG_IMAGE_HEIGHT, 13'd0);
        n_items = 18;
      end else if (p == 7) begin
        cfg_write(REG_IMAGE_WIDTH, 13'd0);
        cfg_write(REG_IMAGE_HEIGHT, 13'h1FFF);
        n_items = 12;
      end else begin
        if (p != 6)
          cfg_write(REG_IMAGE_WIDTH, {2'($urandom_range(3)), 11'($urandom_range(2, 7))});
        if (p != 5)
          cfg_write(REG_IMAGE_HEIGHT, 13'($urandom_range(2, 5)));
        n_items = 20;
      end
      for (int k = 0; k < n_items; k++) begin
        if ((p == 1 || p == 2) && k == 13) settle_idle();
        push_pixel(rand_pixel(), 1'b0, '0);
      end
    end

    settle_idle();
    mismatches += blur_q.size();
    if (mismatches == 0) begin
      $display("box_blur_3x3_edge_average: match");
    end else begin
      $display("box_blur_3x3_edge_average: mismatch");
    end
    $finish;
  end

endmodule
